// File: design/bq_pkg.sv
// Shared types, register indexes and constants for the Q15 biquad filter.
package bq_pkg;

    // Sample and term widths
    localparam int SAMPLE_W = 16;
    localparam int TERM_W   = 17;
    localparam int ACC_W    = 20;

    // Rounding bias and saturation limit
    localparam logic signed [31:0]        ROUND_BIAS = 32'sd16384;
    localparam logic signed [SAMPLE_W-1:0] SAT_POS   = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAT_NEG   = 16'sh8001;
    localparam logic signed [SAMPLE_W-1:0] HIST_RESET = 16'sh8001;

    // Coefficient reset values
    localparam logic signed [SAMPLE_W-1:0] B0_RESET = 16'sh10C8;
    localparam logic signed [SAMPLE_W-1:0] B1_RESET = 16'sh2190;
    localparam logic signed [SAMPLE_W-1:0] B2_RESET = 16'sh10C8;
    localparam logic signed [SAMPLE_W-1:0] A1_RESET = 16'sh5FB7;
    localparam logic signed [SAMPLE_W-1:0] A2_RESET = 16'shDD28;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_B0 = 3'd0,
        REG_B1 = 3'd1,
        REG_B2 = 3'd2,
        REG_A1 = 3'd3,
        REG_A2 = 3'd4
    } bq_reg_idx_t;

    // Coefficient set handed to the datapath
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] b0;
        logic signed [SAMPLE_W-1:0] b1;
        logic signed [SAMPLE_W-1:0] b2;
        logic signed [SAMPLE_W-1:0] a1;
        logic signed [SAMPLE_W-1:0] a2;
    } bq_coef_t;

endpackage

// File: design/bq_if.sv
// Stream interfaces for the input and filtered sample channels.
interface bq_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

interface bq_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

// File: design/bq_term.sv
// One filter term: coefficient times tap, Q15 rounding with sticky bit, shift by 15.
module bq_term
    import bq_pkg::*;
(
    input  logic signed [SAMPLE_W-1:0] coef,
    input  logic signed [SAMPLE_W-1:0] tap,
    output logic signed [TERM_W-1:0]   term
);

    logic signed [31:0] prod;
    logic signed [31:0] biased;
    logic        [31:0] sticky;

    // Product and rounding bias; the product stays within 2^30
    assign prod   = coef * tap;
    assign biased = prod + ROUND_BIAS;

    // Any bits below the binary point force bit 15
    always_comb
    begin
        sticky = biased;
        if (|biased[14:0])
        begin
            sticky[15] = 1'b1;
        end
    end

    // Arithmetic shift right by 15 keeps the top bits
    assign term = sticky[31:15];

endmodule

// File: design/bq_coef_regs.sv
// Coefficient register file written through the configuration port.
module bq_coef_regs
    import bq_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [SAMPLE_W-1:0] cfg_data,
    output bq_coef_t            coef
);

    bq_coef_t coef_reg;
    bq_coef_t coef_next;

    // Decode the write; out-of-range indexes are dropped
    always_comb
    begin
        coef_next = coef_reg;
        if (cfg_we)
        begin
            case (bq_reg_idx_t'(cfg_index))
                REG_B0:  coef_next.b0 = cfg_data;
                REG_B1:  coef_next.b1 = cfg_data;
                REG_B2:  coef_next.b2 = cfg_data;
                REG_A1:  coef_next.a1 = cfg_data;
                REG_A2:  coef_next.a2 = cfg_data;
                default: coef_next = coef_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg.b0 <= B0_RESET;
            coef_reg.b1 <= B1_RESET;
            coef_reg.b2 <= B2_RESET;
            coef_reg.a1 <= A1_RESET;
            coef_reg.a2 <= A2_RESET;
        end
        else
        begin
            coef_reg <= coef_next;
        end
    end

    assign coef = coef_reg;

endmodule

// File: design/bq_datapath.sv
// Filter history, the five terms, their sum and symmetric saturation.
module bq_datapath
    import bq_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  bq_coef_t                   coef,
    input  logic signed [SAMPLE_W-1:0] x,
    input  logic                       advance,
    output logic signed [SAMPLE_W-1:0] y
);

    logic signed [SAMPLE_W-1:0] xh1_reg, xh2_reg, yh1_reg, yh2_reg;
    logic signed [TERM_W-1:0]   t_b0, t_b1, t_b2, t_a1, t_a2;
    logic signed [ACC_W-1:0]    acc;

    // Five products in parallel
    bq_term u_t_b0 (.coef(coef.b0), .tap(x),       .term(t_b0));
    bq_term u_t_b1 (.coef(coef.b1), .tap(xh1_reg), .term(t_b1));
    bq_term u_t_b2 (.coef(coef.b2), .tap(xh2_reg), .term(t_b2));
    bq_term u_t_a1 (.coef(coef.a1), .tap(yh1_reg), .term(t_a1));
    bq_term u_t_a2 (.coef(coef.a2), .tap(yh2_reg), .term(t_a2));

    // Adder tree
    assign acc = ACC_W'(t_b0) + ACC_W'(t_b1) + ACC_W'(t_b2)
               + ACC_W'(t_a1) + ACC_W'(t_a2);

    // Clip to +/-32767
    always_comb
    begin
        if (acc > ACC_W'(SAT_POS))
        begin
            y = SAT_POS;
        end
        else if (acc < ACC_W'(SAT_NEG))
        begin
            y = SAT_NEG;
        end
        else
        begin
            y = acc[SAMPLE_W-1:0];
        end
    end

    // History shifts once per processed word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xh1_reg <= HIST_RESET;
            xh2_reg <= HIST_RESET;
            yh1_reg <= HIST_RESET;
            yh2_reg <= HIST_RESET;
        end
        else if (advance)
        begin
            xh2_reg <= xh1_reg;
            xh1_reg <= x;
            yh2_reg <= yh1_reg;
            yh1_reg <= y;
        end
    end

endmodule

// File: design/q15_biquad_iir_filter.sv
// Top level of the Q15 direct-form-I biquad filter.
//
//  channel   role      payload            handshake
//  -------   -------   ----------------   -----------------------
//  samples   sink      sample_in  [15:0]  valid / ready
//  filtered  source    sample_out [15:0]  valid / ready
//  cfg       write     cfg_data   [15:0]  cfg_we, cfg_index [2:0]
//
// One word per cycle sustained while the filtered channel is ready. An accepted word passes
// through the input register, then five multiplies and the adder tree, into the result register.
// The history takes each new result in the same cycle as the result register does.
// Reset clears the history to -32767 and loads the default coefficients.
// A stalled result holds; the input register keeps taking a word while it is empty.
module q15_biquad_iir_filter
    import bq_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    bq_in_if.sink               samples,
    bq_out_if.source            filtered,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [SAMPLE_W-1:0] cfg_data
);

    bq_coef_t                   coef;
    logic                       in_valid_reg;
    logic signed [SAMPLE_W-1:0] x_reg;
    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] y_reg;
    logic signed [SAMPLE_W-1:0] y_next;
    logic                       advance;
    logic                       take;

    bq_coef_regs u_coef (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .coef      (coef)
    );

    bq_datapath u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .coef    (coef),
        .x       (x_reg),
        .advance (advance),
        .y       (y_next)
    );

    // Pipeline flow control
    assign advance       = in_valid_reg && (!out_valid_reg || filtered.ready);
    assign samples.ready = !in_valid_reg || advance;
    assign take          = samples.valid && samples.ready;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (samples.ready)
        begin
            in_valid_reg <= samples.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            x_reg <= samples.sample_in;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || filtered.ready)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            y_reg <= y_next;
        end
    end

    assign filtered.valid      = out_valid_reg;
    assign filtered.sample_out = y_reg;

endmodule

// File: design/bq_checker.sv
// Port-level checker for the biquad filter, bound to the top level.
module bq_checker
    import bq_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input logic [SAMPLE_W-1:0] out_data
);

    logic [2:0] pending_reg;
    logic [2:0] pending_next;

    // Words accepted but not yet delivered
    always_comb
    begin
        pending_next = pending_reg;
        if (in_valid && in_ready && !(out_valid && out_ready))
        begin
            pending_next = pending_reg + 3'd1;
        end
        else if (!(in_valid && in_ready) && out_valid && out_ready)
        begin
            pending_next = pending_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 3'd0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // A stalled result holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    // Saturation is symmetric: the most negative code never appears
    a_no_min: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data != 16'h8000)
        else $error("result outside saturation range");

    // No result without an accepted word behind it
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 3'd0)
        else $error("result with nothing outstanding");

    // Back-pressure only when both registers are full
    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> pending_reg == 3'd2)
        else $error("input stalled with room left");

    // Never more than two words in flight
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg == 3'd0 || pending_reg == 3'd1 || pending_reg == 3'd2)
        else $error("too many words in flight");

endmodule

bind q15_biquad_iir_filter bq_checker u_bq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .out_valid (filtered.valid),
    .out_ready (filtered.ready),
    .out_data  (filtered.sample_out)
);
